FILE: rtl/greedy_edge_coloring_unit_defines.svh
// Assertion macros used by the execution side (gec_back) of the edge coloring RTL.
`ifndef GREEDY_EDGE_COLORING_UNIT_DEFINES_SVH
`define GREEDY_EDGE_COLORING_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define GEC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GEC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gec_pkg.sv
// Types and constants shared by the edge coloring unit.
`timescale 1ns / 1ps
package gec_pkg;

    localparam int VTX_W      = 10;
    localparam int COLOR_W    = 6;
    localparam int MAP_W      = 63;
    localparam int EPOCH_W    = 8;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;
    localparam int IN_DEPTH   = 4;
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    typedef enum logic {
        KIND_EDGE,
        KIND_TOTAL
    } gec_kind_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_ISSUE,
        ST_COMPUTE,
        ST_FINISH
    } gec_state_t;

    typedef struct packed {
        logic             is_edge;
        logic             last;
        logic [VTX_W-1:0] hi;
        logic [VTX_W-1:0] lo;
    } gec_item_t;

    typedef struct packed {
        gec_kind_t          kind;
        logic [VTX_W-1:0]   edge_low;
        logic [VTX_W-1:0]   edge_high;
        logic [COLOR_W-1:0] color;
        logic               overflow;
        logic               last;
    } gec_result_t;

endpackage

FILE: rtl/gec_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module gec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    output logic [WIDTH-1:0]                         rdata_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: rtl/gec_fifo.sv
// Small register FIFO with occupancy count.
`timescale 1ns / 1ps
module gec_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  logic [WIDTH-1:0]             din,
    output logic                         full,
    input  logic                         pop,
    output logic [WIDTH-1:0]             dout,
    output logic                         empty,
    output logic [$clog2(DEPTH + 1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: rtl/gec_front.sv
// Input side: classify arcs and queue the items that produce results.
`timescale 1ns / 1ps
module gec_front
    import gec_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] from_vertex, [19:10] to_vertex
    input  logic                 s_tuser,   // [0] arc_valid
    input  logic                 s_tlast,
    output logic                 item_valid,
    input  logic                 item_pop,
    output gec_item_t            item
);

    localparam int IW = $bits(gec_item_t);

    logic [VTX_W-1:0] from_v, to_v;
    logic             in_range;
    gec_item_t        cls;
    logic             q_full, q_empty, q_push;
    logic [IW-1:0]    q_dout;
    logic [$clog2(IN_DEPTH + 1)-1:0] q_count;

    assign from_v   = s_tdata[VTX_W-1:0];
    assign to_v     = s_tdata[2*VTX_W-1:VTX_W];
    assign in_range = (32'(from_v) < 32'(MAX_VERTICES)) && (32'(to_v) < 32'(MAX_VERTICES));

    always_comb begin
        cls.is_edge = s_tuser && (from_v < to_v) && in_range;
        cls.last    = s_tlast;
        cls.lo      = from_v;
        cls.hi      = to_v;
    end

    // drop arcs that neither color an edge nor close the graph
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && (cls.is_edge || cls.last);

    gec_fifo #(
        .WIDTH (IW),
        .DEPTH (IN_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (cls),
        .full    (q_full),
        .pop     (item_pop),
        .dout    (q_dout),
        .empty   (q_empty),
        .count   (q_count)
    );

    assign item_valid = !q_empty && (q_count != '0);
    assign item       = gec_item_t'(q_dout);

endmodule

FILE: rtl/gec_back.sv
// Execution side: vertex bitmap memory, first-fit color search, results.
`timescale 1ns / 1ps
`include "greedy_edge_coloring_unit_defines.svh"
module gec_back
    import gec_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_DEGREE   = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    output logic                 item_pop,
    input  gec_item_t            item,
    input  logic [OUT_CNT_W-1:0] out_count,
    output logic                 res_push,
    output gec_result_t          res
);

    localparam int AW          = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int RAM_W       = EPOCH_W + MAP_W;
    localparam int COLOR_LIMIT = 2 * MAX_DEGREE - 1;
    localparam logic [MAP_W-1:0] LIMIT_MASK = (MAP_W'(1) << COLOR_LIMIT) - MAP_W'(1);

    gec_state_t         state_reg, state_next;
    gec_item_t          cur_reg, cur_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [COLOR_W-1:0] highest_reg, highest_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic               fwd_valid_reg, fwd_valid_next;
    logic [VTX_W-1:0]   fwd_lo_reg, fwd_lo_next;
    logic [VTX_W-1:0]   fwd_hi_reg, fwd_hi_next;
    logic [MAP_W-1:0]   fwd_lo_word_reg, fwd_lo_word_next;
    logic [MAP_W-1:0]   fwd_hi_word_reg, fwd_hi_word_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [RAM_W-1:0]   ram_wdata;
    logic [RAM_W-1:0]   rd_lo, rd_hi;

    logic [OUT_CNT_W-1:0] out_free;
    logic               clr_done, epoch_wrap;
    logic [MAP_W-1:0]   eff_lo, eff_hi, used, free_bits, first;
    logic [MAP_W-1:0]   new_lo_word, new_hi_word;
    logic [COLOR_W-1:0] color;
    logic               success;

    gec_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_VERTICES)
    ) u_map (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (AW'(32'(item.lo))),
        .rdata_a (rd_lo),
        .raddr_b (AW'(32'(item.hi))),
        .rdata_b (rd_hi)
    );

    assign out_free   = OUT_CNT_W'(OUT_DEPTH) - out_count;
    assign clr_done   = (clr_addr_reg == AW'(MAX_VERTICES - 1));
    assign epoch_wrap = (epoch_reg == {EPOCH_W{1'b1}});

    // current-graph view of both endpoints, with bypass of the previous edge
    always_comb begin
        eff_lo = (rd_lo[RAM_W-1:MAP_W] == epoch_reg) ? rd_lo[MAP_W-1:0] : '0;
        eff_hi = (rd_hi[RAM_W-1:MAP_W] == epoch_reg) ? rd_hi[MAP_W-1:0] : '0;
        if (fwd_valid_reg && fwd_lo_reg == cur_reg.lo) begin
            eff_lo = fwd_lo_word_reg;
        end else if (fwd_valid_reg && fwd_hi_reg == cur_reg.lo) begin
            eff_lo = fwd_hi_word_reg;
        end
        if (fwd_valid_reg && fwd_lo_reg == cur_reg.hi) begin
            eff_hi = fwd_lo_word_reg;
        end else if (fwd_valid_reg && fwd_hi_reg == cur_reg.hi) begin
            eff_hi = fwd_hi_word_reg;
        end
    end

    always_comb begin
        used      = eff_lo | eff_hi | ~LIMIT_MASK;
        free_bits = ~used;
        first     = free_bits & (~free_bits + MAP_W'(1));
        color     = '0;
        for (int k = 0; k < MAP_W; k++) begin
            color = color | ({COLOR_W{first[k]}} & COLOR_W'(k + 1));
        end
        success     = cur_reg.is_edge && (first != '0);
        new_lo_word = eff_lo | first;
        new_hi_word = eff_hi | first;
    end

    // outputs per state
    always_comb begin
        item_pop      = 1'b0;
        res_push      = 1'b0;
        res.kind      = KIND_EDGE;
        res.edge_low  = cur_reg.lo;
        res.edge_high = cur_reg.hi;
        res.color     = color;
        res.overflow  = !success;
        res.last      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = AW'(32'(cur_reg.lo));
        ram_wdata     = {epoch_reg, new_lo_word};
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_ISSUE: begin
                item_pop = item_valid && (out_free >= OUT_CNT_W'(2));
            end
            ST_COMPUTE: begin
                res_push = cur_reg.is_edge;
                ram_we   = success;
            end
            ST_FINISH: begin
                ram_we    = fwd_valid_reg;
                ram_waddr = AW'(32'(cur_reg.hi));
                ram_wdata = {epoch_reg, fwd_hi_word_reg};
                if (cur_reg.last) begin
                    res_push      = 1'b1;
                    res.kind      = KIND_TOTAL;
                    res.edge_low  = '0;
                    res.edge_high = '0;
                    res.color     = highest_reg;
                    res.overflow  = 1'b0;
                    res.last      = 1'b1;
                    item_pop      = item_valid && !epoch_wrap
                                    && (out_free >= OUT_CNT_W'(3));
                end else begin
                    item_pop = item_valid && (out_free >= OUT_CNT_W'(2));
                end
            end
            default: begin
                item_pop = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_done) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (item_pop) begin
                    state_next = ST_COMPUTE;
                end
            end
            ST_COMPUTE: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (cur_reg.last && epoch_wrap) begin
                    state_next = ST_CLEAR;
                end else if (item_pop) begin
                    state_next = ST_COMPUTE;
                end else begin
                    state_next = ST_ISSUE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // datapath register updates
    always_comb begin
        cur_next         = item_pop ? item : cur_reg;
        epoch_next       = epoch_reg;
        highest_next     = highest_reg;
        clr_addr_next    = clr_addr_reg;
        fwd_valid_next   = fwd_valid_reg;
        fwd_lo_next      = fwd_lo_reg;
        fwd_hi_next      = fwd_hi_reg;
        fwd_lo_word_next = fwd_lo_word_reg;
        fwd_hi_word_next = fwd_hi_word_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_done ? '0 : clr_addr_reg + AW'(1);
            end
            ST_COMPUTE: begin
                fwd_valid_next   = success;
                fwd_lo_next      = cur_reg.lo;
                fwd_hi_next      = cur_reg.hi;
                fwd_lo_word_next = new_lo_word;
                fwd_hi_word_next = new_hi_word;
                if (success && color > highest_reg) begin
                    highest_next = color;
                end
            end
            ST_FINISH: begin
                if (cur_reg.last) begin
                    fwd_valid_next = 1'b0;
                    highest_next   = '0;
                    epoch_next     = epoch_reg + EPOCH_W'(1);
                end
            end
            default: begin
                clr_addr_next = clr_addr_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            epoch_reg     <= '0;
            highest_reg   <= '0;
            clr_addr_reg  <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            highest_reg   <= highest_next;
            clr_addr_reg  <= clr_addr_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg         <= cur_next;
        fwd_lo_reg      <= fwd_lo_next;
        fwd_hi_reg      <= fwd_hi_next;
        fwd_lo_word_reg <= fwd_lo_word_next;
        fwd_hi_word_reg <= fwd_hi_word_next;
    end

    `GEC_ASSERT_IMPL(a_pop_reserves_room, aclk, aresetn, item_pop, out_free >= OUT_CNT_W'(2), "item taken without result room")
    `GEC_ASSERT_IMPL(a_push_not_full, aclk, aresetn, res_push, out_count != OUT_CNT_W'(OUT_DEPTH), "result pushed into full queue")
    `GEC_ASSERT_IMPL(a_clear_quiet, aclk, aresetn, state_reg == ST_CLEAR, !item_pop && !res_push, "activity during clear pass")
    `GEC_ASSERT_NEXT(a_graph_end_resets, aclk, aresetn, state_reg == ST_FINISH && cur_reg.last, highest_reg == '0 && !fwd_valid_reg, "graph state not reset")

endmodule

FILE: rtl/greedy_edge_coloring_unit.sv
// Top level of the greedy first-fit edge coloring unit.
//
// Arcs enter on the s_ stream; an arc with from_vertex < to_vertex, both below MAX_VERTICES and
// arc_valid set, is an edge and gets the lowest color (from 1 up to 2*MAX_DEGREE-1) free at both
// endpoints, returned on the m_ stream; other arcs give no edge result. The item with tlast set
// also returns the highest color of the graph (tlast on the output) and starts a new graph.
// Each item that produces a result passes through a compute and a finish state in the
// execution side, since the per-vertex color bitmap memory has a single write port and both
// endpoint bitmaps are updated; items with no result are dropped at the input. After reset,
// and after every 256th graph, a clearing pass sweeps every address of the bitmap memory,
// during which no item is taken.
`timescale 1ns / 1ps
module greedy_edge_coloring_unit
    import gec_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_DEGREE   = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] from_vertex, [19:10] to_vertex, zero pad
    input  logic                 s_tuser,   // [0] arc_valid
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [9:0] edge_low, [19:10] edge_high,
                                            // [25:20] color_value, [26] overflow, zero pad
    output logic                 m_tuser,   // [0] result_kind
    output logic                 m_tlast
);

    localparam int RW = $bits(gec_result_t);

    logic                 item_valid, item_pop;
    gec_item_t            item;
    logic                 res_push;
    gec_result_t          res, head;
    logic [RW-1:0]        out_dout;
    logic                 out_full, out_empty;
    logic [OUT_CNT_W-1:0] out_count;

    gec_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item)
    );

    gec_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item),
        .out_count  (out_count),
        .res_push   (res_push),
        .res        (res)
    );

    gec_fifo #(
        .WIDTH (RW),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (res_push && !out_full),
        .din     (res),
        .full    (out_full),
        .pop     (m_tvalid && m_tready),
        .dout    (out_dout),
        .empty   (out_empty),
        .count   (out_count)
    );

    assign head     = gec_result_t'(out_dout);
    assign m_tvalid = !out_empty;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;
    assign m_tdata  = {5'd0, head.overflow, head.color, head.edge_high, head.edge_low};

endmodule

FILE: test/greedy_edge_coloring_unit_tb.sv
// Self-checking testbench for the greedy first-fit edge coloring unit.
`timescale 1ns / 1ps
module greedy_edge_coloring_unit_tb;
    import gec_pkg::*;

    localparam int VERTEX_COUNT = 1024;
    localparam int DEGREE_BOUND = 32;
    localparam int COLOR_LIMIT  = (2 * DEGREE_BOUND - 1 < MAP_W) ? 2 * DEGREE_BOUND - 1 : MAP_W;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic             arc_valid;
        logic [VTX_W-1:0] from_v;
        logic [VTX_W-1:0] to_v;
        logic             last;
    } arc_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [9:0] from_vertex, [19:10] to_vertex, zero pad
    logic                 s_tuser  = 1'b0; // [0] arc_valid
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [9:0] edge_low, [19:10] edge_high,
                                           // [25:20] color_value, [26] overflow, zero pad
    logic                 m_tuser;         // [0] result_kind
    logic                 m_tlast;

    arc_t        arcs_to_send[$];
    gec_result_t colorings_due[$];

    logic [MAP_W-1:0]   color_map [VERTEX_COUNT];
    logic [COLOR_W-1:0] top_color = '0;

    int items_sent     = 0;
    int edges_colored  = 0;
    int overflows      = 0;
    int totals_seen    = 0;
    int results_seen   = 0;
    int errors         = 0;
    int hold_left      = 0;
    bit held_once      = 1'b0;

    greedy_edge_coloring_unit #(
        .MAX_VERTICES (VERTEX_COUNT),
        .MAX_DEGREE   (DEGREE_BOUND)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    function automatic int idle_phase();
        return (items_sent / PHASE_ITEMS) % 4;
    endfunction

    function automatic bit sender_gap();
        case (idle_phase())
            1: return $urandom_range(0, 99) < 62;
            3: return $urandom_range(0, 99) < 17;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_gap();
        case (idle_phase())
            2: return $urandom_range(0, 99) < 62;
            3: return $urandom_range(0, 99) < 17;
            default: return 1'b0;
        endcase
    endfunction

    function automatic string fmt_result(gec_result_t r);
        return $sformatf("kind=%0d low=%0d high=%0d color=%0d ovf=%0b last=%0b",
                         r.kind, r.edge_low, r.edge_high, r.color, r.overflow, r.last);
    endfunction

    task automatic clear_graph();
        for (int v = 0; v < VERTEX_COUNT; v++)
            color_map[v] = '0;
        top_color = '0;
    endtask

    // First-fit coloring of one accepted transaction.
    task automatic color_arc(input logic valid, input logic [VTX_W-1:0] a,
                             input logic [VTX_W-1:0] b, input logic last);
        logic [MAP_W-1:0]   used;
        logic [COLOR_W-1:0] pick;
        gec_result_t        r;
        if (valid && a < b && int'(a) < VERTEX_COUNT && int'(b) < VERTEX_COUNT) begin
            used = color_map[a] | color_map[b];
            pick = '0;
            for (int k = 0; k < COLOR_LIMIT; k++)
                if (!used[k] && pick == 0)
                    pick = COLOR_W'(k + 1);
            r.kind      = KIND_EDGE;
            r.edge_low  = a;
            r.edge_high = b;
            r.color     = pick;
            r.overflow  = (pick == 0);
            r.last      = 1'b0;
            if (pick != 0) begin
                color_map[a][pick - 1'b1] = 1'b1;
                color_map[b][pick - 1'b1] = 1'b1;
                if (pick > top_color)
                    top_color = pick;
                edges_colored++;
            end else begin
                overflows++;
            end
            colorings_due.insert(colorings_due.size(), r);
        end
        if (last) begin
            r.kind      = KIND_TOTAL;
            r.edge_low  = '0;
            r.edge_high = '0;
            r.color     = top_color;
            r.overflow  = 1'b0;
            r.last      = 1'b1;
            colorings_due.insert(colorings_due.size(), r);
            totals_seen++;
            clear_graph();
        end
    endtask

    task automatic push_arc(input logic valid, input logic [VTX_W-1:0] a,
                            input logic [VTX_W-1:0] b, input logic last);
        arc_t itm;
        itm.arc_valid = valid;
        itm.from_v    = a;
        itm.to_v      = b;
        itm.last      = last;
        arcs_to_send.insert(arcs_to_send.size(), itm);
    endtask

    always @(posedge aclk) begin : drive_p
        arc_t itm;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                color_arc(s_tuser, s_tdata[VTX_W-1:0], s_tdata[2*VTX_W-1:VTX_W], s_tlast);
                items_sent <= items_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (arcs_to_send.size() != 0 && !sender_gap()) begin
                    itm = arcs_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W - 2*VTX_W){1'b0}}, itm.to_v, itm.from_v};
                    s_tuser  <= itm.arc_valid;
                    s_tlast  <= itm.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Hold off the result side once, long enough to back up the input.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!held_once && items_sent >= 40) begin
            hold_left <= HOLD_CYCLES;
            held_once <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        m_tready <= (hold_left == 0) && !receiver_gap();
    end

    always @(posedge aclk) begin : check_p
        gec_result_t got;
        gec_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind      = gec_kind_t'(m_tuser);
            got.edge_low  = m_tdata[VTX_W-1:0];
            got.edge_high = m_tdata[2*VTX_W-1:VTX_W];
            got.color     = m_tdata[2*VTX_W+COLOR_W-1:2*VTX_W];
            got.overflow  = m_tdata[2*VTX_W+COLOR_W];
            got.last      = m_tlast;
            results_seen++;
            if (colorings_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, actual %s",
                         $time, fmt_result(got));
            end else begin
                want = colorings_due.pop_front();
                if (got.kind !== want.kind || got.edge_low !== want.edge_low ||
                    got.edge_high !== want.edge_high || got.color !== want.color ||
                    got.overflow !== want.overflow || got.last !== want.last) begin
                    errors++;
                    $display("%0t: mismatch, expected %s, actual %s",
                             $time, fmt_result(want), fmt_result(got));
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stim_p
        logic [VTX_W-1:0] pool [12];
        logic [VTX_W-1:0] x, y, lo, hi, center, leaf;
        int pool_n, n_arcs, kind, drain;
        bit end_on_arc;

        clear_graph();

        // empty graph, then basic coloring across endpoint extremes
        push_arc(1'b0, 10'd0, 10'd0, 1'b1);
        push_arc(1'b1, 10'd0, 10'd1023, 1'b0);
        push_arc(1'b1, 10'd1023, 10'd0, 1'b0);
        push_arc(1'b1, 10'd5, 10'd5, 1'b0);
        push_arc(1'b0, 10'd2, 10'd3, 1'b0);
        push_arc(1'b1, 10'd0, 10'd1, 1'b0);
        push_arc(1'b1, 10'd1, 10'd1023, 1'b0);
        push_arc(1'b1, 10'd511, 10'd512, 1'b1);
        // graph end on a reversed arc and on a marker with nonzero fields
        push_arc(1'b1, 10'd1023, 10'd1022, 1'b1);
        push_arc(1'b0, 10'd1022, 10'd1023, 1'b1);
        push_arc(1'b1, 10'd1022, 10'd1023, 1'b1);
        push_arc(1'b0, 10'd1023, 10'd1023, 1'b0);
        push_arc(1'b1, 10'd341, 10'd682, 1'b0);
        push_arc(1'b1, 10'd682, 10'd341, 1'b1);
        // star exhausting every color at the center, then overflow
        for (int i = 1; i <= 64; i++)
            push_arc(1'b1, 10'd100, 10'(100 + i), 1'b0);
        push_arc(1'b1, 10'd100, 10'd200, 1'b0);
        push_arc(1'b1, 10'd200, 10'd300, 1'b1);

        while (arcs_to_send.size() < 1000) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                pool_n = $urandom_range(2, 12);
                for (int i = 0; i < pool_n; i++)
                    pool[i] = VTX_W'($urandom_range(0, 1023));
                n_arcs     = $urandom_range(1, 24);
                end_on_arc = $urandom_range(0, 99) < 70;
                for (int i = 0; i < n_arcs; i++) begin
                    x    = pool[$urandom_range(0, pool_n - 1)];
                    y    = pool[$urandom_range(0, pool_n - 1)];
                    lo   = (x < y) ? x : y;
                    hi   = (x < y) ? y : x;
                    kind = $urandom_range(0, 99);
                    if (kind < 85)
                        push_arc(1'b1, lo, hi, end_on_arc && i == n_arcs - 1);
                    else if (kind < 90)
                        push_arc(1'b1, hi, lo, end_on_arc && i == n_arcs - 1);
                    else if (kind < 93)
                        push_arc(1'b1, x, x, end_on_arc && i == n_arcs - 1);
                    else if (kind < 97)
                        push_arc(1'b0, VTX_W'($urandom_range(0, 1023)),
                                 VTX_W'($urandom_range(0, 1023)),
                                 end_on_arc && i == n_arcs - 1);
                    else
                        push_arc(1'b1, VTX_W'($urandom_range(0, 1023)),
                                 VTX_W'($urandom_range(0, 1023)),
                                 end_on_arc && i == n_arcs - 1);
                end
                if (!end_on_arc) begin
                    if ($urandom_range(0, 1))
                        push_arc(1'b0, VTX_W'($urandom_range(0, 1023)),
                                 VTX_W'($urandom_range(0, 1023)), 1'b1);
                    else
                        push_arc(1'b1, pool[0], pool[0] - VTX_W'($urandom_range(0, 1)), 1'b1);
                end
            end else if (kind < 88) begin
                center     = VTX_W'($urandom_range(0, 1023));
                n_arcs     = $urandom_range(55, 70);
                end_on_arc = $urandom_range(0, 1);
                for (int i = 0; i < n_arcs; i++) begin
                    leaf = center + VTX_W'(i + 1);
                    lo   = (leaf < center) ? leaf : center;
                    hi   = (leaf < center) ? center : leaf;
                    push_arc(1'b1, lo, hi, end_on_arc && i == n_arcs - 1);
                end
                if (!end_on_arc)
                    push_arc(1'b0, VTX_W'($urandom_range(0, 1023)),
                             VTX_W'($urandom_range(0, 1023)), 1'b1);
            end else begin
                n_arcs = $urandom_range(1, 8);
                for (int i = 0; i < n_arcs; i++)
                    push_arc(1'($urandom_range(0, 1)), VTX_W'($urandom_range(0, 1023)),
                             VTX_W'($urandom_range(0, 1023)), $urandom_range(0, 99) < 20);
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (arcs_to_send.size() != 0 || s_tvalid)
            @(posedge aclk);
        drain = 0;
        while (colorings_due.size() != 0 && drain < 20000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (20) @(posedge aclk);

        if (colorings_due.size() != 0) begin
            errors += colorings_due.size();
            $display("%0t: %0d expected transactions never arrived, first %s",
                     $time, colorings_due.size(), fmt_result(colorings_due[0]));
        end
        $display("Sent %0d arcs; checked %0d results: %0d colored edges, %0d overflows,",
                 items_sent, results_seen, edges_colored, overflows);
        $display("%0d graph totals, with one long output stall and four idle patterns.",
                 totals_seen);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/gec_pkg.sv
rtl/gec_ram.sv
rtl/gec_fifo.sv
rtl/gec_front.sv
rtl/gec_back.sv
rtl/greedy_edge_coloring_unit.sv
test/greedy_edge_coloring_unit_tb.sv
